[sv/kam_pkg.sv]
package kam_pkg;

    localparam int SYM_W       = 5;
    localparam int SYM_SLOTS   = 12;
    localparam int SYM_VEC_W   = SYM_SLOTS * SYM_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int M_TDATA_W   = 32;
    localparam int CFG_DATA_W  = 55;

    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [7:0]  VERSION_RESET = 8'd48;

    typedef enum logic [2:0] {
        CFG_VERSION_BYTE   = 3'd0,
        CFG_PREFIX_SYMBOLS = 3'd1,
        CFG_PREFIX_LENGTH  = 3'd2,
        CFG_SUFFIX_SYMBOLS = 3'd3,
        CFG_SUFFIX_LENGTH  = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_HEAD,
        PH_KEY,
        PH_CRC_LO,
        PH_CRC_HI,
        PH_FLUSH
    } phase_t;

    typedef struct packed {
        logic [7:0]  version_byte;
        logic [54:0] prefix_symbols;
        logic [3:0]  prefix_length;
        logic [49:0] suffix_symbols;
        logic [3:0]  suffix_length;
    } kam_cfg_t;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       first;
        logic       last;
    } kam_entry_t;

    // CRC-16/XMODEM over one byte, MSB first
    function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [6:0] base32_char(logic [4:0] idx);
        if (idx < 5'd26) begin
            return 7'h41 + {2'b00, idx};
        end else begin
            return 7'h32 + {2'b00, idx - 5'd26};
        end
    endfunction

    function automatic logic [4:0] sym_at(logic [SYM_VEC_W-1:0] vec, logic [3:0] idx);
        if (idx < 4'(SYM_SLOTS)) begin
            return vec[idx*SYM_W +: SYM_W];
        end else begin
            return '0;
        end
    endfunction

endpackage

[sv/kam_front.sv]
module kam_front #(
    parameter int KEY_BYTES = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  queue_full,
    output logic                  push,
    output kam_pkg::kam_entry_t   push_entry
);

    localparam logic [5:0] LAST_IDX = 6'(KEY_BYTES - 1);

    logic [5:0] byte_cnt_reg, byte_cnt_next;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        push_entry.key_byte = s_tdata;
        push_entry.first    = (byte_cnt_reg == 6'd0);
        push_entry.last     = (byte_cnt_reg == LAST_IDX);
        byte_cnt_next       = byte_cnt_reg;
        if (push) begin
            byte_cnt_next = push_entry.last ? 6'd0 : byte_cnt_reg + 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_cnt_reg <= '0;
        end else begin
            byte_cnt_reg <= byte_cnt_next;
        end
    end

endmodule

[sv/kam_queue.sv]
module kam_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  kam_pkg::kam_entry_t   push_entry,
    input  logic                  pop,
    output logic                  full,
    output logic                  head_valid,
    output kam_pkg::kam_entry_t   head
);

    localparam int PW = kam_pkg::QUEUE_PTR_W;

    kam_pkg::kam_entry_t entry_reg [kam_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;

    assign full       = (count_reg == (PW+1)'(kam_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("queue popped while empty");

endmodule

[sv/kam_encoder.sv]
module kam_encoder #(
    parameter int KEY_BYTES  = 32,
    parameter int PREFIX_MAX = 11,
    parameter int SUFFIX_MAX = 10
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  kam_pkg::kam_cfg_t                  cfg,
    input  logic                               head_valid,
    input  kam_pkg::kam_entry_t                head,
    output logic                               pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [kam_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tlast
);

    localparam int         ADDR_CHARS   = ((KEY_BYTES + 3) * 8 + 4) / 5;
    localparam logic [6:0] ADDR_CHARS_W = 7'(ADDR_CHARS);
    localparam logic [3:0] PMAX         = 4'(PREFIX_MAX);
    localparam logic [3:0] SMAX         = 4'(SUFFIX_MAX);

    kam_pkg::phase_t phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    logic [6:0]  buf_reg, buf_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [5:0]  pos_reg, pos_next;
    logic        prefix_ok_reg, prefix_ok_next;
    logic        suffix_ok_reg, suffix_ok_next;
    logic        out_valid_reg, out_valid_next;
    logic [kam_pkg::M_TDATA_W-1:0] tdata_reg, tdata_next;
    logic        tlast_reg, tlast_next;

    logic        can_emit, go, merge, last_char, prefix_ok_new, suffix_ok_new;
    logic [7:0]  byte_sel;
    logic [11:0] acc;
    logic [4:0]  sym;
    logic [2:0]  cnt_after;
    logic [6:0]  pos7, suf_start, suf_k;
    logic [3:0]  plen, slen;
    logic [kam_pkg::SYM_VEC_W-1:0] pvec, svec;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;

    always_comb begin
        can_emit  = !out_valid_reg || m_tready;
        go        = can_emit && (cnt_reg >= 3'd5 || head_valid);
        merge     = (cnt_reg < 3'd5) && (phase_reg != kam_pkg::PH_FLUSH);
        last_char = (phase_reg == kam_pkg::PH_FLUSH) && (cnt_reg <= 3'd5);

        unique case (phase_reg)
            kam_pkg::PH_HEAD:   byte_sel = head.first ? cfg.version_byte : head.key_byte;
            kam_pkg::PH_KEY:    byte_sel = head.key_byte;
            kam_pkg::PH_CRC_LO: byte_sel = crc_reg[7:0];
            kam_pkg::PH_CRC_HI: byte_sel = crc_reg[15:8];
            default:            byte_sel = '0;
        endcase
        acc = {buf_reg[3:0], byte_sel};

        // drain a full symbol, merge the next byte, or shift out the tail
        if (cnt_reg >= 3'd5) begin
            cnt_after = cnt_reg - 3'd5;
            sym       = 5'(buf_reg >> cnt_after);
            buf_next  = buf_reg & ((7'd1 << cnt_after) - 7'd1);
        end else if (merge) begin
            cnt_after = cnt_reg + 3'd3;
            sym       = 5'(acc >> (cnt_reg + 3'd3));
            buf_next  = acc[6:0] & ((7'd1 << cnt_after) - 7'd1);
        end else begin
            cnt_after = '0;
            sym       = 5'(buf_reg[4:0] << (3'd5 - cnt_reg));
            buf_next  = '0;
        end

        pos7      = {1'b0, pos_reg};
        plen      = (cfg.prefix_length > PMAX) ? PMAX : cfg.prefix_length;
        slen      = (cfg.suffix_length > SMAX) ? SMAX : cfg.suffix_length;
        if ({3'b000, slen} > ADDR_CHARS_W) begin
            slen = ADDR_CHARS_W[3:0];
        end
        pvec      = kam_pkg::SYM_VEC_W'(cfg.prefix_symbols);
        svec      = kam_pkg::SYM_VEC_W'(cfg.suffix_symbols);
        suf_start = ADDR_CHARS_W - {3'b000, slen};
        suf_k     = pos7 - suf_start;

        prefix_ok_new = prefix_ok_reg;
        if (pos7 < {3'b000, plen} && kam_pkg::sym_at(pvec, pos_reg[3:0]) != sym) begin
            prefix_ok_new = 1'b0;
        end
        suffix_ok_new = suffix_ok_reg;
        if (slen != 4'd0 && pos7 >= suf_start && pos7 < ADDR_CHARS_W
                && kam_pkg::sym_at(svec, suf_k[3:0]) != sym) begin
            suffix_ok_new = 1'b0;
        end

        phase_next     = phase_reg;
        crc_next       = crc_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        prefix_ok_next = prefix_ok_reg;
        suffix_ok_next = suffix_ok_reg;
        pop            = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        tdata_next     = tdata_reg;
        tlast_next     = tlast_reg;

        if (go) begin
            out_valid_next = 1'b1;
            tlast_next     = last_char;
            tdata_next     = {2'b00,
                              last_char ? crc_reg : 16'h0000,
                              last_char && prefix_ok_new && suffix_ok_new,
                              pos_reg,
                              kam_pkg::base32_char(sym)};
            if (last_char) begin
                // address done: drop the entry and start over
                pop            = 1'b1;
                phase_next     = kam_pkg::PH_HEAD;
                crc_next       = '0;
                cnt_next       = '0;
                buf_next       = '0;
                pos_next       = '0;
                prefix_ok_next = 1'b1;
                suffix_ok_next = 1'b1;
            end else begin
                cnt_next       = cnt_after;
                pos_next       = pos_reg + 6'd1;
                prefix_ok_next = prefix_ok_new;
                suffix_ok_next = suffix_ok_new;
                if (merge) begin
                    unique case (phase_reg)
                        kam_pkg::PH_HEAD: begin
                            crc_next = kam_pkg::crc16_byte(crc_reg, byte_sel);
                            if (head.first) begin
                                phase_next = kam_pkg::PH_KEY;
                            end else if (head.last) begin
                                phase_next = kam_pkg::PH_CRC_LO;
                            end else begin
                                pop = 1'b1;
                            end
                        end
                        kam_pkg::PH_KEY: begin
                            crc_next = kam_pkg::crc16_byte(crc_reg, byte_sel);
                            if (head.last) begin
                                phase_next = kam_pkg::PH_CRC_LO;
                            end else begin
                                phase_next = kam_pkg::PH_HEAD;
                                pop        = 1'b1;
                            end
                        end
                        kam_pkg::PH_CRC_LO: phase_next = kam_pkg::PH_CRC_HI;
                        kam_pkg::PH_CRC_HI: phase_next = kam_pkg::PH_FLUSH;
                        default:            phase_next = phase_reg;
                    endcase
                end
            end
        end else begin
            buf_next = buf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= kam_pkg::PH_HEAD;
            crc_reg       <= '0;
            buf_reg       <= '0;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            prefix_ok_reg <= 1'b1;
            suffix_ok_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            crc_reg       <= crc_next;
            buf_reg       <= buf_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            prefix_ok_reg <= prefix_ok_next;
            suffix_ok_reg <= suffix_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tdata_reg <= tdata_next;
        tlast_reg <= tlast_next;
    end

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (go && last_char) |=> (pos_reg == 6'd0 && cnt_reg == 3'd0
                               && phase_reg == kam_pkg::PH_HEAD))
        else $error("state not cleared after last character");

    a_entry_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != kam_pkg::PH_HEAD) |-> head_valid)
        else $error("entry lost in the middle of its sequence");

    a_tail_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !tlast_reg) |-> (tdata_reg[29:13] == '0))
        else $error("match or checksum set on a non-final character");

endmodule

[sv/key_address_encode_match_unit.sv]
// Key bytes pass through the queue to the encoder, whose character output is registered.
// Throughput: one character per cycle while m_tready is high and the queue holds an entry;
// an address of KEY_BYTES bytes gives ((KEY_BYTES + 3) * 8 + 4) / 5 characters (56 for 32 bytes),
// sent through the single-character output stage of the encoder.
// A four-entry queue lets the input side run ahead of the encoder.
// Reset clears the address state; the registers return to version 48 and empty patterns.
module key_address_encode_match_unit #(
    parameter int KEY_BYTES  = 32,
    parameter int PREFIX_MAX = 11,
    parameter int SUFFIX_MAX = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] key_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [6:0] symbol_char, [12:7] symbol_position, [13] key_matches, [29:14] checksum
    output logic [kam_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tlast,   // last_symbol
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [2:0]                          cfg_index,
    input  logic [kam_pkg::CFG_DATA_W-1:0]      cfg_data
);

    kam_pkg::kam_cfg_t   cfg_reg, cfg_next;
    kam_pkg::kam_entry_t push_entry, head;
    logic push, pop, queue_full, head_valid;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                kam_pkg::CFG_VERSION_BYTE:   cfg_next.version_byte   = cfg_data[7:0];
                kam_pkg::CFG_PREFIX_SYMBOLS: cfg_next.prefix_symbols = cfg_data[54:0];
                kam_pkg::CFG_PREFIX_LENGTH:  cfg_next.prefix_length  = cfg_data[3:0];
                kam_pkg::CFG_SUFFIX_SYMBOLS: cfg_next.suffix_symbols = cfg_data[49:0];
                kam_pkg::CFG_SUFFIX_LENGTH:  cfg_next.suffix_length  = cfg_data[3:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.version_byte   <= kam_pkg::VERSION_RESET;
            cfg_reg.prefix_symbols <= '0;
            cfg_reg.prefix_length  <= '0;
            cfg_reg.suffix_symbols <= '0;
            cfg_reg.suffix_length  <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    kam_front #(
        .KEY_BYTES (KEY_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    kam_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head)
    );

    kam_encoder #(
        .KEY_BYTES  (KEY_BYTES),
        .PREFIX_MAX (PREFIX_MAX),
        .SUFFIX_MAX (SUFFIX_MAX)
    ) u_encoder (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

[bench/kam_address_checker.sv]
`timescale 1ns / 1ps

module kam_address_checker #(
    parameter int KEY_BYTES  = 32,
    parameter int PREFIX_MAX = 11,
    parameter int SUFFIX_MAX = 10,
    parameter int ADDR_CHARS = ((KEY_BYTES + 3) * 8 + 4) / 5
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [7:0]                        s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [kam_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              m_tlast,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [2:0]                        cfg_index,
    input  logic [kam_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int                                mismatch_count,
    output int                                chars_outstanding,
    // symbol indexes of the last finished address, position p in bits 5p+4..5p
    output logic [5*ADDR_CHARS-1:0]           recent_address
);

    localparam logic [15:0] XMODEM_POLY = 16'h1021;
    localparam logic [8*32-1:0] SYMBOL_GLYPHS = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";

    typedef struct packed {
        logic [6:0]  sym_char;
        logic [5:0]  position;
        logic        last;
        logic        matched;
        logic [15:0] crc;
    } addr_char_t;

    // register copies
    logic [7:0]  cfg_version;
    logic [54:0] lead_syms;
    logic [3:0]  lead_len;
    logic [49:0] tail_syms;
    logic [3:0]  tail_len;

    // address state
    logic [15:0] crc_acc;
    logic [11:0] spill_bits;
    logic [2:0]  spill_count;
    logic [5:0]  key_count;
    logic [5:0]  char_count;
    logic        lead_ok;
    logic        tail_ok;
    logic [5*ADDR_CHARS-1:0] addr_syms;

    addr_char_t pending_chars[$];

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] d);
        logic [15:0] r;
        logic        fb;
        r = c;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ d[i];
            r  = {r[14:0], 1'b0} ^ (fb ? XMODEM_POLY : 16'h0000);
        end
        return r;
    endfunction

    task automatic clear_address();
        crc_acc     = '0;
        spill_bits  = '0;
        spill_count = '0;
        key_count   = '0;
        char_count  = '0;
        lead_ok     = 1'b1;
        tail_ok     = 1'b1;
        addr_syms   = '0;
    endtask

    task automatic emit_char(input logic [4:0] idx);
        int         plen;
        int         slen;
        int         pos;
        int         k;
        addr_char_t c;
        pos  = int'(char_count);
        plen = (lead_len > PREFIX_MAX) ? PREFIX_MAX : int'(lead_len);
        slen = (tail_len > SUFFIX_MAX) ? SUFFIX_MAX : int'(tail_len);
        if (slen > ADDR_CHARS) slen = ADDR_CHARS;
        if (pos < plen && lead_syms[5*pos +: 5] != idx) lead_ok = 1'b0;
        if (slen > 0 && pos >= ADDR_CHARS - slen && pos < ADDR_CHARS) begin
            k = pos - (ADDR_CHARS - slen);
            if (tail_syms[5*k +: 5] != idx) tail_ok = 1'b0;
        end
        if (pos < ADDR_CHARS) addr_syms[5*pos +: 5] = idx;
        c.sym_char = SYMBOL_GLYPHS[8*(31 - int'(idx)) +: 7];
        c.position = char_count;
        c.last     = 1'b0;
        c.matched  = 1'b0;
        c.crc      = '0;
        pending_chars.push_back(c);
        char_count = char_count + 6'd1;
    endtask

    // append eight bits MSB first and cut off every full five-bit group
    task automatic shift_in_byte(input logic [7:0] b);
        int unsigned acc;
        int          cnt;
        acc = (int'(spill_bits) << 8) | int'(b);
        cnt = int'(spill_count) + 8;
        while (cnt >= 5) begin
            emit_char(5'(acc >> (cnt - 5)));
            cnt -= 5;
        end
        spill_bits  = 12'(acc & ((1 << cnt) - 1));
        spill_count = 3'(cnt);
    endtask

    task automatic encode_key_byte(input logic [7:0] kb);
        logic [15:0] done_crc;
        addr_char_t  tail;
        if (key_count == 0) begin
            crc_acc = crc_step(crc_acc, cfg_version);
            shift_in_byte(cfg_version);
        end
        crc_acc = crc_step(crc_acc, kb);
        shift_in_byte(kb);
        key_count = key_count + 6'd1;
        if (key_count >= KEY_BYTES || key_count == 0) begin
            done_crc = crc_acc;
            shift_in_byte(done_crc[7:0]);
            shift_in_byte(done_crc[15:8]);
            if (spill_count > 0) emit_char(5'(spill_bits << (5 - spill_count)));
            // flag the closing character with match and checksum
            tail         = pending_chars.pop_back();
            tail.last    = 1'b1;
            tail.matched = lead_ok && tail_ok;
            tail.crc     = done_crc;
            pending_chars.push_back(tail);
            recent_address <= addr_syms;
            clear_address();
        end
    endtask

    task automatic apply_reg(input logic [2:0] idx,
                             input logic [kam_pkg::CFG_DATA_W-1:0] data);
        case (kam_pkg::cfg_index_t'(idx))
            kam_pkg::CFG_VERSION_BYTE:   cfg_version = data[7:0];
            kam_pkg::CFG_PREFIX_SYMBOLS: lead_syms   = data[54:0];
            kam_pkg::CFG_PREFIX_LENGTH:  lead_len    = data[3:0];
            kam_pkg::CFG_SUFFIX_SYMBOLS: tail_syms   = data[49:0];
            kam_pkg::CFG_SUFFIX_LENGTH:  tail_len    = data[3:0];
            default: ;
        endcase
    endtask

    task automatic check_char();
        addr_char_t got;
        addr_char_t want;
        got.sym_char = m_tdata[6:0];
        got.position = m_tdata[12:7];
        got.matched  = m_tdata[13];
        got.crc      = m_tdata[29:14];
        got.last     = m_tlast;
        if (pending_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected char %h at position %0d",
                                      got.sym_char, got.position));
        end else begin
            want = pending_chars.pop_front();
            if (got.sym_char !== want.sym_char || got.position !== want.position ||
                got.last !== want.last || got.matched !== want.matched ||
                got.crc !== want.crc) begin
                report_mismatch($sformatf(
                    "char/pos/last/match/crc got %h/%0d/%b/%b/%h want %h/%0d/%b/%b/%h",
                    got.sym_char, got.position, got.last, got.matched, got.crc,
                    want.sym_char, want.position, want.last, want.matched, want.crc));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_version = kam_pkg::VERSION_RESET;
            lead_syms   = '0;
            lead_len    = '0;
            tail_syms   = '0;
            tail_len    = '0;
            clear_address();
            pending_chars.delete();
            mismatch_count = 0;
            recent_address <= '0;
        end else begin
            if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) encode_key_byte(s_tdata);
            if (m_tvalid && m_tready) check_char();
        end
        chars_outstanding <= pending_chars.size();
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int KEY_BYTES  = 32;
    localparam int PREFIX_MAX = 11;
    localparam int SUFFIX_MAX = 10;
    localparam int ADDR_CHARS = ((KEY_BYTES + 3) * 8 + 4) / 5;
    localparam logic [2:0] CFG_SPARE_INDEX = 3'd5;
    localparam int ADDRESSES = 7;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [7:0]                     s_tdata;   // [7:0] key_byte
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    // [6:0] char, [12:7] position, [13] match, [29:14] crc
    logic [kam_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           m_tlast;   // last_symbol
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [2:0]                     cfg_index;
    logic [kam_pkg::CFG_DATA_W-1:0] cfg_data;

    int                        mismatch_count;
    int                        chars_outstanding;
    logic [5*ADDR_CHARS-1:0]   recent_address;

    logic       idle_enable = 1'b1;
    logic [7:0] key_buf[KEY_BYTES];
    logic [7:0] cur_version;

    key_address_encode_match_unit #(
        .KEY_BYTES (KEY_BYTES),
        .PREFIX_MAX(PREFIX_MAX),
        .SUFFIX_MAX(SUFFIX_MAX)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    kam_address_checker #(
        .KEY_BYTES (KEY_BYTES),
        .PREFIX_MAX(PREFIX_MAX),
        .SUFFIX_MAX(SUFFIX_MAX)
    ) u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tlast          (m_tlast),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatch_count   (mismatch_count),
        .chars_outstanding(chars_outstanding),
        .recent_address   (recent_address)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (idle_enable) begin
            m_tready <= ($urandom_range(99) >= 8);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // leave cfg_valid high; the caller drops it after the last write
    task automatic write_reg(input logic [2:0] idx,
                             input logic [kam_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic load_settings(input logic [7:0] ver, input logic [54:0] ps,
                                 input logic [3:0] pl, input logic [49:0] ss,
                                 input logic [3:0] sl);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        // random upper bits must be ignored by the narrow registers
        write_reg(kam_pkg::CFG_VERSION_BYTE,   {junk[54:8], ver});
        write_reg(kam_pkg::CFG_PREFIX_SYMBOLS, ps);
        write_reg(kam_pkg::CFG_PREFIX_LENGTH,  {junk[54:4], pl});
        write_reg(kam_pkg::CFG_SUFFIX_SYMBOLS, {junk[54:50], ss});
        write_reg(kam_pkg::CFG_SUFFIX_LENGTH,  {junk[54:4], sl});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_key_byte(input logic [7:0] kb);
        if (idle_enable) begin
            while ($urandom_range(99) < 8) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= kb;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_key_span(input int lo, input int hi);
        for (int i = lo; i <= hi; i++) send_key_byte(key_buf[i]);
    endtask

    task automatic wait_chars_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (chars_outstanding != 0) @(posedge aclk);
    endtask

    function automatic logic [54:0] address_slice(logic [5*ADDR_CHARS-1:0] syms,
                                                  int first, int count);
        logic [54:0] v;
        v = '0;
        for (int i = 0; i < count; i++) v[5*i +: 5] = syms[5*(first + i) +: 5];
        return v;
    endfunction

    initial begin
        int          scenario;
        int          eff_p;
        int          eff_s;
        int          slot;
        logic [3:0]  plen;
        logic [3:0]  slen;
        logic [54:0] psyms;
        logic [54:0] ssyms;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extreme bytes and all-ones patterns with over-long lengths
        cur_version = 8'hff;
        write_reg(CFG_SPARE_INDEX, kam_pkg::CFG_DATA_W'({$urandom, $urandom}));
        load_settings(cur_version, '1, 4'd15, '1, 4'd15);
        for (int i = 0; i < KEY_BYTES; i++) key_buf[i] = 8'(i * 29 + 7);
        key_buf[0] = 8'h00;
        key_buf[1] = 8'hff;
        key_buf[2] = 8'h80;
        key_buf[3] = 8'h01;
        key_buf[4] = 8'haa;
        key_buf[5] = 8'h55;
        key_buf[KEY_BYTES-1] = 8'hff;
        send_key_span(0, KEY_BYTES - 1);
        wait_chars_drained();

        for (int a = 0; a < ADDRESSES; a++) begin
            idle_enable = !(a == 3 || a == 4);
            scenario = (a == 0) ? 1 : $urandom_range(3);
            plen = 4'($urandom_range(15));
            slen = 4'($urandom_range(15));
            if (scenario == 0) begin
                // fresh key under random patterns
                case ($urandom_range(4))
                    0:       cur_version = 8'h00;
                    1:       cur_version = 8'hff;
                    2:       cur_version = 8'd48;
                    3:       cur_version = 8'd144;
                    default: cur_version = 8'($urandom);
                endcase
                for (int i = 0; i < KEY_BYTES; i++) begin
                    if ($urandom_range(9) == 0) begin
                        key_buf[i] = $urandom_range(1) ? 8'hff : 8'h00;
                    end else begin
                        key_buf[i] = 8'($urandom);
                    end
                end
                psyms = {$urandom, $urandom};
                ssyms = {$urandom, $urandom};
            end else begin
                // resend the last key with patterns taken from its address (scenario 3 flips one pattern bit)
                eff_p = (plen > PREFIX_MAX) ? PREFIX_MAX : int'(plen);
                eff_s = (slen > SUFFIX_MAX) ? SUFFIX_MAX : int'(slen);
                psyms = address_slice(recent_address, 0, PREFIX_MAX);
                ssyms = address_slice(recent_address, ADDR_CHARS - eff_s, eff_s);
                if (scenario == 3 && (eff_p > 0 || eff_s > 0)) begin
                    if (eff_s == 0 || (eff_p > 0 && $urandom_range(1) == 0)) begin
                        slot = 5 * $urandom_range(eff_p - 1) + $urandom_range(4);
                        psyms[slot] = ~psyms[slot];
                    end else begin
                        slot = 5 * $urandom_range(eff_s - 1) + $urandom_range(4);
                        ssyms[slot] = ~ssyms[slot];
                    end
                end
            end
            load_settings(cur_version, psyms, plen, ssyms[49:0], slen);
            if (a == 5) begin
                // change the suffix pattern partway through the address
                send_key_span(0, 12);
                wait_chars_drained();
                load_settings(cur_version, psyms, plen, 50'({$urandom, $urandom}),
                              4'($urandom_range(15)));
                send_key_span(13, KEY_BYTES - 1);
            end else begin
                send_key_span(0, KEY_BYTES - 1);
            end
            wait_chars_drained();
        end

        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && chars_outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
